/* rtl/mtfe_pkg.sv */
package mtfe_pkg;

    localparam int MAX_BINS = 4096;
    localparam int CNT_W    = $clog2(MAX_BINS);
    localparam int KW       = (CNT_W > 13) ? CNT_W : 13;

    localparam logic [7:0] REG_MIN_BIN   = 8'd0;
    localparam logic [7:0] REG_PEAK_BIN  = 8'd1;
    localparam logic [7:0] REG_MAX_BIN   = 8'd2;
    localparam logic [7:0] REG_BINS_USED = 8'd3;

    localparam logic [44:0] ENERGY_MAX = '1;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    typedef struct packed {
        logic [11:0] min_bin;
        logic [11:0] peak_bin;
        logic [11:0] max_bin;
        logic [12:0] bins_used;
    } t_cfg;

    typedef enum logic {
        ALU_TRIAL,
        ALU_MUL
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_RAD,
        S_SQRT,
        S_DIV,
        S_MAC_MUL,
        S_MAC_ADD,
        S_DONE
    } t_state;

endpackage

/* rtl/mtfe_cfg.sv */
module mtfe_cfg import mtfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_bin   <= 12'd0;
            r_cfg.peak_bin  <= 12'd1;
            r_cfg.max_bin   <= 12'd2;
            r_cfg.bins_used <= 13'd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_BIN:   r_cfg.min_bin   <= i_cfg_data[11:0];
                REG_PEAK_BIN:  r_cfg.peak_bin  <= i_cfg_data[11:0];
                REG_MAX_BIN:   r_cfg.max_bin   <= i_cfg_data[11:0];
                REG_BINS_USED: r_cfg.bins_used <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/mtfe_alu.sv */
module mtfe_alu import mtfe_pkg::*; (
    input  t_alu_op     i_op,
    input  logic [18:0] i_x,
    input  logic [18:0] i_y,
    output logic [32:0] o_res   // trial: {ge, diff}; mul: product
);

    logic [19:0] diff;

    assign diff = {1'b0, i_x} - {1'b0, i_y};

    always_comb begin
        unique case (i_op)
            ALU_MUL:   o_res = {17'b0, i_x[15:0]} * {16'b0, i_y[16:0]};
            ALU_TRIAL: o_res = {13'b0, ~diff[19], diff[18:0]};
            default:   o_res = '0;
        endcase
    end

endmodule

/* rtl/mel_triangular_filter_energy.sv */
// Triangular filterbank channel: weighted magnitude sum of one spectrum frame.
// Input stream s: one complex bin per transfer, tlast on the final bin of a frame.
// Output stream m: one energy word per frame, given after the bin with tlast.
// Config channel: register index and data, always ready; write only while idle.
// Bins outside the triangle or at/past bins_used are skipped and the sequencer
// stays idle; a skipped last bin goes straight to the output load. For a weighted
// bin the squares and the product go through the shared multiplier: squares first,
// then a 16-step square root and a 17-step weight division (left out when the bin
// sits on a peak equal to max) on the shared trial subtractor, then the product.
// After the frame's last bin, the output register is loaded in S_DONE.
// s_tready is high only while the sequencer is idle.
// If the receiver stalls, the result holds in the output register; the next
// frame may be processed meanwhile, and its last bin waits until the held
// result is taken.
// Reset clears the bin counter, accumulator and output valid and loads the
// register defaults min=0, peak=1, max=2, bins_used=4096.
module mel_triangular_filter_energy import mtfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // real_part[15:0], imag_part[31:16]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // energy[44:0], zero[47:45]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg        cfg;
    t_state      r_state, n_state;
    t_alu_op     alu_op;
    logic [18:0] alu_x, alu_y;
    logic [32:0] alu_res;
    logic        alu_ge;

    logic [CNT_W-1:0] r_bin_cnt;
    logic [44:0]      r_acc;
    logic             r_out_valid;
    logic [44:0]      r_energy;

    logic [15:0] r_re, r_im, r_root;
    logic [11:0] r_num, r_den;
    logic [16:0] r_weight, r_rem;
    logic [31:0] r_rad;
    logic [32:0] r_prod;
    logic [4:0]  r_step;
    logic        r_one, r_last;

    logic             accept, out_free, rising, one, skip;
    logic [KW-1:0]    k_w, num_w;
    logic [15:0]      re_abs, im_abs;
    logic [45:0]      sum;
    logic [CNT_W-1:0] cnt_next;

    mtfe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mtfe_alu u_alu (
        .i_op  (alu_op),
        .i_x   (alu_x),
        .i_y   (alu_y),
        .o_res (alu_res)
    );

    assign alu_ge = alu_res[19];

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // window decode for the current bin index
    assign k_w    = KW'(r_bin_cnt);
    assign rising = k_w < KW'(cfg.peak_bin);
    assign num_w  = rising ? (k_w - KW'(cfg.min_bin)) : (KW'(cfg.max_bin) - k_w);
    assign one    = !rising && (cfg.max_bin == cfg.peak_bin);
    assign skip   = !((k_w < KW'(cfg.bins_used)) && (k_w >= KW'(cfg.min_bin))
                      && (k_w <= KW'(cfg.max_bin)));

    assign re_abs = i_s_tdata[15] ? (16'd0 - i_s_tdata[15:0]) : i_s_tdata[15:0];
    assign im_abs = i_s_tdata[31] ? (16'd0 - i_s_tdata[31:16]) : i_s_tdata[31:16];

    assign cnt_next = (r_bin_cnt == CNT_W'(MAX_BINS - 1)) ? '0 : r_bin_cnt + 1'b1;
    assign sum      = {1'b0, r_acc} + 46'(r_prod);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (accept) n_state = skip ? (i_s_tlast ? S_DONE : S_IDLE) : S_SQ_RE;
            S_SQ_RE:   n_state = S_SQ_IM;
            S_SQ_IM:   n_state = S_RAD;
            S_RAD:     n_state = S_SQRT;
            S_SQRT:    if (r_step == 5'd15) n_state = r_one ? S_MAC_MUL : S_DIV;
            S_DIV:     if (r_step == 5'd16) n_state = S_MAC_MUL;
            S_MAC_MUL: n_state = S_MAC_ADD;
            S_MAC_ADD: n_state = r_last ? S_DONE : S_IDLE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        alu_op     = ALU_TRIAL;
        alu_x      = '0;
        alu_y      = '0;
        unique case (r_state)
            S_SQ_RE: begin
                alu_op = ALU_MUL;
                alu_x  = {3'b0, r_re};
                alu_y  = {3'b0, r_re};
            end
            S_SQ_IM: begin
                alu_op = ALU_MUL;
                alu_x  = {3'b0, r_im};
                alu_y  = {3'b0, r_im};
            end
            S_SQRT: begin
                alu_x = {r_rem, r_rad[31:30]};
                alu_y = {1'b0, r_root, 2'b01};
            end
            S_DIV: begin
                alu_x = (r_step == 5'd0) ? {7'b0, r_num} : {6'b0, r_rem[11:0], 1'b0};
                alu_y = {7'b0, r_den};
            end
            S_MAC_MUL: begin
                alu_op = ALU_MUL;
                alu_x  = {3'b0, r_root};
                alu_y  = {2'b0, r_weight};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_cnt   <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_acc       <= '0;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_bin_cnt <= i_s_tlast ? '0 : cnt_next;
            end
            if (r_state == S_MAC_ADD) begin
                r_acc <= sum[45] ? ENERGY_MAX : sum[44:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_re     <= re_abs;
                    r_im     <= im_abs;
                    r_num    <= num_w[11:0];
                    r_den    <= rising ? (cfg.peak_bin - cfg.min_bin)
                                       : (cfg.max_bin - cfg.peak_bin);
                    r_one    <= one;
                    r_weight <= one ? WEIGHT_ONE : '0;
                    r_last   <= i_s_tlast;
                    r_rem    <= '0;
                    r_root   <= '0;
                    r_step   <= '0;
                end
            end
            S_SQ_RE: r_rad  <= alu_res[31:0];
            S_SQ_IM: r_prod <= alu_res;
            S_RAD:   r_rad  <= r_rad + r_prod[31:0];
            S_SQRT: begin
                r_rem  <= alu_ge ? alu_res[16:0] : alu_x[16:0];
                r_root <= {r_root[14:0], alu_ge};
                r_rad  <= {r_rad[29:0], 2'b00};
                r_step <= (r_step == 5'd15) ? 5'd0 : r_step + 5'd1;
            end
            S_DIV: begin
                r_rem    <= {5'b0, alu_ge ? alu_res[11:0] : alu_x[11:0]};
                r_weight <= {r_weight[15:0], alu_ge};
                r_step   <= r_step + 5'd1;
            end
            S_MAC_MUL: r_prod <= alu_res;
            S_DONE: begin
                if (out_free) r_energy <= r_acc;
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b0, r_energy};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !skip |=> !o_s_tready)
        else $error("input taken while sequencer busy");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !i_m_tready |=> (r_state == S_DONE))
        else $error("result loaded over a pending output");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_step != 5'd0) |-> (r_rem < {5'b0, r_den}))
        else $error("division remainder out of range");

    a_sqrt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_step <= 5'd15))
        else $error("square root step count overrun");
`endif

endmodule

/* bench/mel_triangular_filter_energy_test.sv */
module mel_triangular_filter_energy_test import mtfe_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BINS    = 1480;
    localparam int SETTLE_CYCLES  = 45;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic {
        ROW_REG,
        ROW_BIN
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [7:0]         idx;
        logic [15:0]        data;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
        bit                 pinned;
        logic [44:0]        energy;
    } t_row;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_COMB
    } t_sink;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // real_part[15:0], imag_part[31:16]
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // energy[44:0], zero[47:45]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // predictor state
    logic [11:0] cfg_min = 12'd0;
    logic [11:0] cfg_peak = 12'd1;
    logic [11:0] cfg_max = 12'd2;
    logic [12:0] cfg_used = 13'd4096;
    logic [11:0] bin_idx = '0;
    logic [44:0] energy_acc = '0;

    logic [44:0] frame_energy_q[$];
    logic [44:0] want_energy;
    t_row        dir_rows[$];
    int          mismatches = 0;
    int          bins_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          sink_left = 0;
    t_sink       sink_mode = SINK_OPEN;

    mel_triangular_filter_energy i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned bin_magnitude(logic signed [15:0] re,
                                                  logic signed [15:0] im);
        longint      power;
        int unsigned root;
        int unsigned probe;
        power = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        root  = 0;
        for (int b = 15; b >= 0; b--) begin
            probe = root | (32'd1 << b);
            if (longint'(probe) * longint'(probe) <= power)
                root = probe;
        end
        return root;
    endfunction

    function automatic logic [16:0] tri_gain(logic [11:0] k);
        if (k < cfg_min || k > cfg_max)
            return '0;
        if (k < cfg_peak)
            return 17'(((32'(k) - 32'(cfg_min)) << 16) / (32'(cfg_peak) - 32'(cfg_min)));
        if (cfg_max == cfg_peak)
            return WEIGHT_ONE;
        return 17'(((32'(cfg_max) - 32'(k)) << 16) / (32'(cfg_max) - 32'(cfg_peak)));
    endfunction

    // adds one bin to the running sum; returns 1 when the frame closes
    function automatic bit fold_bin(logic signed [15:0] re, logic signed [15:0] im,
                                    logic last, output logic [44:0] energy);
        logic [16:0]     gain;
        longint unsigned sum;
        gain = (13'(bin_idx) < cfg_used) ? tri_gain(bin_idx) : '0;
        if (gain != '0) begin
            sum = 64'(energy_acc) + 64'(bin_magnitude(re, im)) * 64'(gain);
            energy_acc = (sum > 64'(ENERGY_MAX)) ? ENERGY_MAX : sum[44:0];
        end
        bin_idx = (bin_idx == 12'(MAX_BINS - 1)) ? '0 : bin_idx + 12'd1;
        energy  = energy_acc;
        if (last) begin
            energy_acc = '0;
            bin_idx    = '0;
        end
        return last;
    endfunction

    function automatic void apply_reg(logic [7:0] idx, logic [15:0] data);
        case (idx)
            REG_MIN_BIN:   cfg_min  = data[11:0];
            REG_PEAK_BIN:  cfg_peak = data[11:0];
            REG_MAX_BIN:   cfg_max  = data[11:0];
            REG_BINS_USED: cfg_used = data[12:0];
            default: ;
        endcase
    endfunction

    function automatic void add_reg(logic [7:0] idx, logic [15:0] data);
        dir_rows.push_back('{ROW_REG, idx, data, '0, '0, 1'b0, 1'b0, '0});
    endfunction

    function automatic void add_bin(logic signed [15:0] re, logic signed [15:0] im,
                                    logic last);
        dir_rows.push_back('{ROW_BIN, '0, '0, re, im, last, 1'b0, '0});
    endfunction

    function automatic void add_frame_end(logic signed [15:0] re, logic signed [15:0] im,
                                          logic [44:0] energy);
        dir_rows.push_back('{ROW_BIN, '0, '0, re, im, 1'b1, 1'b1, energy});
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_bound();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_bin(logic signed [15:0] re, logic signed [15:0] im, logic last,
                            bit pinned, logic [44:0] pinned_energy);
        int          gap;
        logic [44:0] energy;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {im, re};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        bins_sent++;
        if (fold_bin(re, im, last, energy))
            frame_energy_q.push_back(pinned ? pinned_energy : energy);
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
    endtask

    // stop the input stream and let the block go idle
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (frame_energy_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_triangle(int lo, int pk, int hi, int used);
        cfg_write(REG_MIN_BIN, {4'($urandom), 12'(lo)});
        cfg_write(REG_PEAK_BIN, {4'($urandom), 12'(pk)});
        cfg_write(REG_MAX_BIN, {4'($urandom), 12'(hi)});
        cfg_write(REG_BINS_USED, {3'($urandom), 13'(used)});
    endtask

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_left  <= $urandom_range(40, 400);
            sink_mode  <= t_sink'($urandom_range(0, 2));
            i_m_tready <= 1'b1;
        end else begin
            sink_left <= sink_left - 1;
            case (sink_mode)
                SINK_OPEN:   i_m_tready <= 1'b1;
                SINK_RANDOM: i_m_tready <= 1'($urandom_range(0, 1));
                default:     i_m_tready <= ((sink_left % 16) > 10);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (frame_energy_q.size() == 0) begin
                report_mismatch($sformatf("energy %0d with none pending", o_m_tdata));
            end else begin
                want_energy = frame_energy_q.pop_front();
                if (o_m_tdata !== {3'b000, want_energy})
                    report_mismatch($sformatf("energy %0d, expected %0d",
                                              o_m_tdata, want_energy));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("mel_triangular_filter_energy test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit cfg_open;
        int stop_at;
        int lo;
        int pk;
        int hi;
        int used;
        int frames;
        int len;

        cfg_open = 1'b0;

        // reset defaults: rising edge at bin 0, weight one at bin 1
        add_bin(16'sd32767, 16'sd0, 1'b0);
        add_frame_end(16'sd3, 16'sd4, 45'd327680);
        add_bin(16'sh8000, 16'sh8000, 1'b0);
        add_frame_end(16'sh8000, 16'sh8000, 45'd3036938240);
        add_frame_end(16'sh7fff, 16'sh8000, 45'd0);
        add_frame_end(-16'sd1, 16'sd1, 45'd0);
        // peak equal to max
        add_reg(REG_MIN_BIN, 16'd0);
        add_reg(REG_PEAK_BIN, 16'd2);
        add_reg(REG_MAX_BIN, 16'd2);
        add_bin(16'sd100, 16'sd0, 1'b0);
        add_bin(16'sd100, 16'sd0, 1'b0);
        add_bin(16'sd100, 16'sd0, 1'b1);
        // empty triangle
        add_reg(REG_MIN_BIN, 16'd5);
        add_reg(REG_PEAK_BIN, 16'd4);
        add_reg(REG_MAX_BIN, 16'd3);
        add_bin(16'sd20000, 16'sd20000, 1'b0);
        add_bin(16'sh7fff, 16'sh7fff, 1'b0);
        add_frame_end(16'sh8000, 16'sh7fff, 45'd0);
        // peak below min
        add_reg(REG_MIN_BIN, 16'd1);
        add_reg(REG_PEAK_BIN, 16'd0);
        add_reg(REG_MAX_BIN, 16'd3);
        add_bin(16'sd1000, -16'sd2000, 1'b0);
        add_bin(16'sd1000, -16'sd2000, 1'b0);
        add_bin(-16'sd30000, 16'sd12345, 1'b0);
        add_bin(16'sd7, 16'sd9, 1'b1);
        // peak above max, bins_used masked above the bin range, dead indexes
        add_reg(REG_MIN_BIN, 16'hf000);
        add_reg(REG_PEAK_BIN, 16'd9);
        add_reg(REG_MAX_BIN, 16'd2);
        add_reg(REG_BINS_USED, 16'hffff);
        add_reg(8'd4, 16'd0);
        add_reg(8'hff, 16'hffff);
        add_bin(16'sd500, 16'sd500, 1'b0);
        add_bin(16'sh8000, 16'sd0, 1'b0);
        add_bin(16'sd0, 16'sh7fff, 1'b1);
        // nothing used
        add_reg(REG_PEAK_BIN, 16'd1);
        add_reg(REG_BINS_USED, 16'd0);
        add_bin(16'sh7fff, 16'sh7fff, 1'b0);
        add_frame_end(16'sh7fff, 16'sh7fff, 45'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_REG) begin
                if (!cfg_open) begin
                    drain_results();
                    cfg_open = 1'b1;
                end
                cfg_write(dir_rows[n].idx, dir_rows[n].data);
            end else begin
                if (cfg_open) begin
                    cfg_close();
                    cfg_open = 1'b0;
                end
                send_bin(dir_rows[n].re, dir_rows[n].im, dir_rows[n].last,
                         dir_rows[n].pinned, dir_rows[n].energy);
            end
        end

        stop_at = bins_sent + RANDOM_BINS;
        while (bins_sent < stop_at) begin
            drain_results();
            lo = $urandom_range(0, 12);
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    pk = lo + $urandom_range(1, 12);
                    hi = pk + $urandom_range(1, 12);
                end
                3: begin
                    pk = lo + $urandom_range(0, 12);
                    hi = pk;
                end
                4: begin
                    lo = $urandom_range(0, 40);
                    pk = $urandom_range(0, 40);
                    hi = $urandom_range(0, 40);
                end
                default: begin
                    lo = pick_bound();
                    pk = pick_bound();
                    hi = pick_bound();
                end
            endcase
            case ($urandom_range(0, 3))
                0, 1:    used = MAX_BINS;
                2:       used = $urandom_range(0, 48);
                default: used = $urandom_range(0, 8191);
            endcase
            write_triangle(lo, pk, hi, used);
            if ($urandom_range(0, 3) == 0)
                cfg_write(8'($urandom_range(4, 255)), 16'($urandom));
            cfg_close();
            frames = $urandom_range(1, 6);
            repeat (frames) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                  : $urandom_range(1, 40);
                for (int n = 0; n < len; n++)
                    send_bin(pick_sample(), pick_sample(), n == len - 1, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("mel_triangular_filter_energy test passed");
        else
            $display("mel_triangular_filter_energy test failed");
        $finish;
    end

endmodule
